/* rtl/itrd_pkg.sv */
// Package for the integer to radix digits block: shared types and constants.
// Used by itrd_ctrl, itrd_dp and integer_to_radix_digits_top.
// Depends on nothing.
`timescale 1ns / 1ps

package itrd_pkg;

    localparam int IN_W      = 32;   // width of the value port
    localparam int RADIX_W   = 5;    // width of the radix register
    localparam int CHAR_W    = 8;    // width of one ASCII character
    localparam int DIGIT_W   = 4;    // width of one digit (radix up to 16)
    localparam int STEP_BITS = 8;    // dividend bits consumed per division cycle

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] BAD_CHAR = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new value
        logic bad;        // emit the single error result
        logic div_step;   // run one step of the long division
        logic emit;       // read out one stored digit
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radix_ok;   // radix register lies in 2..16
        logic last_chunk; // this division cycle finishes a digit
        logic quot_zero;  // quotient after this cycle is zero
        logic last_read;  // this read fetches the least significant digit
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h41;
            4'd11:   c = 8'h42;
            4'd12:   c = 8'h43;
            4'd13:   c = 8'h44;
            4'd14:   c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

/* rtl/itrd_ctrl.sv */
// Controller of the integer to radix digits block: sequences division and readout.
// Depends on itrd_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module itrd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  itrd_pkg::sts_t sts,
    output itrd_pkg::cmd_t cmd,
    output logic          busy
);

    itrd_pkg::state_t state_reg;
    itrd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b1;
        unique case (state_reg)
            itrd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (sts.radix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = itrd_pkg::ST_DIVIDE;
                    end
                    else
                    begin
                        // An invalid radix yields one error result and no work.
                        cmd.bad = 1'b1;
                    end
                end
            end
            itrd_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.last_chunk && sts.quot_zero)
                begin
                    state_next = itrd_pkg::ST_EMIT;
                end
            end
            itrd_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.last_read)
                begin
                    state_next = itrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/itrd_dp.sv */
// Datapath of the integer to radix digits block: radix register, long divider,
// digit store and result register. Depends on itrd_pkg.
`timescale 1ns / 1ps

module itrd_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itrd_pkg::cmd_t                cmd,
    output itrd_pkg::sts_t                sts,
    input  logic [itrd_pkg::IN_W-1:0]     value,
    input  logic                          cfg_write,
    input  logic [itrd_pkg::RADIX_W-1:0]  cfg_data,
    output logic                          result_valid,
    output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last_digit,
    output logic                          bad_radix
);

    localparam int CHUNKS = (VALUE_WIDTH + itrd_pkg::STEP_BITS - 1) / itrd_pkg::STEP_BITS;
    localparam int PAD_W  = CHUNKS * itrd_pkg::STEP_BITS;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(CHUNKS - 1);

    logic [itrd_pkg::RADIX_W-1:0]  radix_reg;
    logic [PAD_W-1:0]              dividend_reg;
    logic [PAD_W-1:0]              dividend_next;
    logic [itrd_pkg::DIGIT_W-1:0]  rem_reg;
    logic [itrd_pkg::DIGIT_W-1:0]  rem_next;
    logic [itrd_pkg::STEP_BITS-1:0] qbits;
    logic [CNT_W-1:0]              chunk_reg;
    logic [ADDR_W-1:0]             wr_ptr_reg;
    logic [ADDR_W-1:0]             rd_ptr_reg;
    logic [PAD_W-1:0]              load_val;
    logic                          digit_done;

    logic [itrd_pkg::DIGIT_W-1:0]  digit_mem [VALUE_WIDTH];
    logic [itrd_pkg::DIGIT_W-1:0]  rd_data_reg;

    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic                          out_bad_reg;

    // Value bits above VALUE_WIDTH are dropped.
    generate
        if (VALUE_WIDTH >= itrd_pkg::IN_W)
        begin : g_wide
            assign load_val = PAD_W'(value);
        end
        else
        begin : g_narrow
            assign load_val = PAD_W'(value[VALUE_WIDTH-1:0]);
        end
    endgenerate

    // Eight steps of restoring division by the radix, most significant bits first.
    always_comb
    begin
        logic [itrd_pkg::RADIX_W-1:0] trial;
        logic [itrd_pkg::DIGIT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < itrd_pkg::STEP_BITS; i++)
        begin
            trial = {r, dividend_reg[PAD_W-1-i]};
            if (trial >= radix_reg)
            begin
                qbits[itrd_pkg::STEP_BITS-1-i] = 1'b1;
                trial = trial - radix_reg;
            end
            else
            begin
                qbits[itrd_pkg::STEP_BITS-1-i] = 1'b0;
            end
            r = trial[itrd_pkg::DIGIT_W-1:0];
        end
        rem_next      = r;
        dividend_next = (dividend_reg << itrd_pkg::STEP_BITS) | PAD_W'(qbits);
    end

    assign digit_done = cmd.div_step && (chunk_reg == LAST_CHUNK);

    assign sts.radix_ok   = (radix_reg >= itrd_pkg::RADIX_MIN) &&
                            (radix_reg <= itrd_pkg::RADIX_MAX);
    assign sts.last_chunk = (chunk_reg == LAST_CHUNK);
    assign sts.quot_zero  = (dividend_next == '0);
    assign sts.last_read  = (rd_ptr_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= itrd_pkg::RADIX_RESET;
            chunk_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                radix_reg <= cfg_data;
            end

            if (cmd.load)
            begin
                chunk_reg  <= '0;
                wr_ptr_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                if (digit_done)
                begin
                    chunk_reg  <= '0;
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                    rd_ptr_reg <= wr_ptr_reg;
                end
                else
                begin
                    chunk_reg <= chunk_reg + 1'b1;
                end
            end
            else if (cmd.emit)
            begin
                rd_ptr_reg <= rd_ptr_reg - 1'b1;
            end

            out_valid_reg <= cmd.emit || cmd.bad;
            out_last_reg  <= cmd.bad || (cmd.emit && (rd_ptr_reg == '0));
            out_bad_reg   <= cmd.bad;
        end
    end

    // Dividend and partial remainder; the remainder restarts at zero per digit.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dividend_reg <= load_val;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= dividend_next;
            rem_reg      <= digit_done ? '0 : rem_next;
        end
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_mem[wr_ptr_reg] <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rd_data_reg <= digit_mem[rd_ptr_reg];
        end
    end

    assign result_valid = out_valid_reg;
    assign last_digit   = out_last_reg;
    assign bad_radix    = out_bad_reg;
    assign digit_char   = out_bad_reg ? itrd_pkg::BAD_CHAR
                                      : itrd_pkg::digit_to_char(rd_data_reg);

endmodule

/* rtl/integer_to_radix_digits_top.sv */
// Top level of the integer to radix digits block.
// Depends on itrd_pkg, itrd_ctrl and itrd_dp.
`timescale 1ns / 1ps

// Converts an unsigned value into ASCII digits in the base held by the radix
// register, most significant digit first, with no leading zeros.
// Requests: a conversion request is taken at a clock edge where start is high
// and busy is low. Each digit appears on digit_char for one cycle with
// result_valid high; last_digit marks the final digit of a request.
// The receiver cannot stall; results must be taken as they appear.
// The radix register (reset value 10) is written through cfg_valid/cfg_ready;
// cfg_ready is high whenever busy is low and no request is presented on start.
// A radix outside 2..16 gives one result with bad_radix and last_digit set,
// in the cycle after the request, and busy never rises.
// The divider consumes eight value bits per cycle and divides the whole value
// by the radix once for each digit; readout then fetches one digit at a time
// through the single read port of the digit store. Busy stays high through
// both division and readout, and the last digit appears in the same cycle
// in which busy falls, since each result is registered.
// Reset clears the controller to idle, drops result_valid and sets radix to 10.

module integer_to_radix_digits_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [itrd_pkg::IN_W-1:0]     value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [itrd_pkg::RADIX_W-1:0]  cfg_data,
    output logic                          result_valid,
    output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last_digit,
    output logic                          bad_radix
);

    itrd_pkg::cmd_t cmd;
    itrd_pkg::sts_t sts;
    logic           cfg_write;

    // A radix write never shares an edge with an accepted request.
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    itrd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    itrd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .bad_radix    (bad_radix)
    );

endmodule
